// ===== src/tng_pkg.sv =====
// Shared types, constants and helper functions for the triangle normal gradient block.
`timescale 1ns / 1ps
package tng_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int LQ_W          = 29;   // floor(sqrt(sum c^2)) < 2^29
  localparam int CMAG_W        = 28;   // normalized cross product magnitude
  localparam int SQ_W          = 60;   // square root work registers
  localparam int DIV_NUM_W     = 128;  // scaled dividend
  localparam int QUO_W         = 31;   // unsaturated quotient bits
  localparam int QDEPTH        = 2;

  localparam logic [31:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [31:0] SAT_NEG = 32'h8000_0000;

  typedef enum logic [3:0] {
    F_IDLE, F_EDGE, F_CROSS, F_MAX, F_BLEN, F_NORM,
    F_SQ, F_SQRT, F_AREA, F_NSTART, F_NWAIT, F_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE, B_PROD, B_TERM, B_DIV, B_WAIT, B_ZERO
  } back_state_t;

  // per-triangle context handed from front to back
  typedef struct packed {
    logic [2:0][2:0][31:0] u;     // u[vertex][axis]
    logic [2:0][31:0]      nrm;
    logic [LQ_W-1:0]       lq;
    logic signed [7:0]     s;
    logic [30:0]           area;
    logic                  degen;
  } tri_ctx_t;

  function automatic logic [31:0] sat_diff(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] d;
    d = {a[31], a} - {b[31], b};
    if (d[32] != d[31]) sat_diff = d[32] ? SAT_NEG : SAT_POS;
    else sat_diff = d[31:0];
  endfunction

  function automatic logic [63:0] mag64(input logic [63:0] x);
    mag64 = x[63] ? (64'd0 - x) : x;
  endfunction

  // mag * 2^sh, right shift when sh is negative
  function automatic logic [DIV_NUM_W-1:0] scale_mag(input logic [63:0] mag,
                                                    input logic signed [7:0] sh);
    logic [DIV_NUM_W-1:0] w;
    logic [7:0] nsh;
    w = DIV_NUM_W'(mag);
    nsh = 8'(-sh);
    if (sh >= 0) w = w << sh[6:0];
    else w = w >> nsh[6:0];
    scale_mag = w;
  endfunction

  // signed, saturated mag * 2^sh (divide by one)
  function automatic logic [31:0] sat_shift(input logic [63:0] mag,
                                            input logic signed [7:0] sh,
                                            input logic neg);
    logic [DIV_NUM_W-1:0] w;
    logic [31:0] v;
    w = scale_mag(mag, sh);
    v = {1'b0, w[30:0]};
    if (|w[DIV_NUM_W-1:31]) sat_shift = neg ? SAT_NEG : SAT_POS;
    else sat_shift = neg ? (32'd0 - v) : v;
  endfunction

endpackage

// ===== src/tng_div.sv =====
// Radix-2 restoring divider with early saturation check, one quotient bit per cycle.
`timescale 1ns / 1ps
module tng_div
  import tng_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [DIV_NUM_W-1:0] num,
  input  logic [LQ_W-1:0]      den,
  input  logic                 neg,
  output logic                 done,
  output logic [31:0]          q
);

  localparam int CW = $clog2(QUO_W + 1);
  localparam int HI_W = DIV_NUM_W - QUO_W;

  logic                active;
  logic [CW-1:0]       cnt;
  logic [LQ_W-1:0]     rem;
  logic [QUO_W-1:0]    low;
  logic [QUO_W-1:0]    quo;
  logic                negr;
  logic [LQ_W:0]       r2;
  logic                ge;
  logic [HI_W-1:0]     hi;
  logic                sat;

  assign hi  = num[DIV_NUM_W-1:QUO_W];
  assign sat = (hi >= HI_W'(den));   // quotient would reach 2^31
  assign r2  = {rem, low[QUO_W-1]};
  assign ge  = (r2 >= {1'b0, den});

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= !sat;
        done   <= sat;
      end else if (active && cnt == '0) begin
        active <= 1'b0;
        done   <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      negr <= neg;
      rem  <= hi[LQ_W-1:0];
      low  <= num[QUO_W-1:0];
      quo  <= '0;
      cnt  <= CW'(QUO_W);
      if (sat) q <= neg ? SAT_NEG : SAT_POS;
    end else if (active) begin
      if (cnt == '0) begin
        q <= negr ? (32'd0 - {1'b0, quo}) : {1'b0, quo};
      end else begin
        rem <= ge ? LQ_W'(r2 - {1'b0, den}) : r2[LQ_W-1:0];
        low <= low << 1;
        quo <= {quo[QUO_W-2:0], ge};
        cnt <= cnt - 1'b1;
      end
    end
  end

endmodule

// ===== src/tng_queue.sv =====
// Short context queue between the triangle front end and the gradient back end.
`timescale 1ns / 1ps
module tng_queue
  import tng_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  logic     pop,
  input  tri_ctx_t din,
  output tri_ctx_t dout,
  output logic     full,
  output logic     empty
);

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

  tri_ctx_t        mem [QDEPTH];
  logic [PW-1:0]   wptr;
  logic [PW-1:0]   rptr;
  logic [PW:0]     cnt;

  assign full  = (cnt == (PW + 1)'(QDEPTH));
  assign empty = (cnt == '0);
  assign dout  = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      cnt  <= '0;
    end else begin
      if (push) wptr <= (wptr == PW'(QDEPTH - 1)) ? '0 : wptr + 1'b1;
      if (pop)  rptr <= (rptr == PW'(QDEPTH - 1)) ? '0 : rptr + 1'b1;
      case ({push, pop})
        2'b10:   cnt <= cnt + 1'b1;
        2'b01:   cnt <= cnt - 1'b1;
        default: cnt <= cnt;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= din;
  end

endmodule

// ===== src/tng_front.sv =====
// Front end: accepts a triangle, forms cross product, length, area and unit normal.
`timescale 1ns / 1ps
module tng_front
  import tng_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [2:0][2:0][31:0] vin,
  output logic                  busy,
  input  logic                  full,
  output logic                  push,
  output tri_ctx_t              ctx
);

  localparam logic signed [7:0] FB8 = 8'(FRAC_BITS);

  front_state_t state, state_next;

  logic [2:0][2:0][31:0] w;
  logic [2:0][31:0]      e1, e2;
  logic [2:0][63:0]      cv;
  logic [2:0][63:0]      cvmag;
  logic [63:0]           mmax;
  logic [63:0]           msh;
  logic [6:0]            bl;
  logic signed [7:0]     s_c;
  logic [7:0]            nsh;
  logic [2:0][CMAG_W-1:0] cmag;
  logic [2:0]            csgn;
  logic [2:0]            step;
  logic [1:0]            nk;
  logic [SQ_W-1:0]       sqx, sqres, sqbit, sqtry;
  logic [31:0]           area_c;

  logic signed [32:0]    mul_a, mul_b;
  logic signed [65:0]    prod;
  logic                  div_start, div_done;
  logic [31:0]           div_q;

  always_comb begin
    for (int k = 0; k < 3; k++) cvmag[k] = mag64(cv[k]);
    mmax = cvmag[0];
    if (cvmag[1] > mmax) mmax = cvmag[1];
    if (cvmag[2] > mmax) mmax = cvmag[2];
  end

  assign s_c    = $signed({1'b0, bl}) - $signed(8'(CMAG_W));
  assign nsh    = 8'(-s_c);
  assign sqtry  = sqres + sqbit;
  assign area_c = sat_shift(64'(sqres), ctx.s - FB8, 1'b0);
  assign prod   = mul_a * mul_b;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      F_IDLE:   if (start) state_next = F_EDGE;
      F_EDGE:   state_next = F_CROSS;
      F_CROSS:  if (step == 3'd5) state_next = F_MAX;
      F_MAX:    state_next = (mmax == '0) ? F_PUSH : F_BLEN;
      F_BLEN:   if (msh == '0) state_next = F_NORM;
      F_NORM:   state_next = F_SQ;
      F_SQ:     if (step == 3'd2) state_next = F_SQRT;
      F_SQRT:   if (sqbit == '0) state_next = F_AREA;
      F_AREA:   state_next = F_NSTART;
      F_NSTART: state_next = F_NWAIT;
      F_NWAIT:  if (div_done) state_next = (nk == 2'd2) ? F_PUSH : F_NSTART;
      F_PUSH:   if (!full) state_next = F_IDLE;
      default:  state_next = F_IDLE;
    endcase
  end

  // outputs and multiplier operand select
  always_comb begin
    busy      = (state != F_IDLE);
    push      = (state == F_PUSH) && !full;
    div_start = (state == F_NSTART);
    mul_a     = '0;
    mul_b     = '0;
    if (state == F_SQ) begin
      mul_a = $signed({5'b0, cmag[step[1:0]]});
      mul_b = $signed({5'b0, cmag[step[1:0]]});
    end else begin
      case (step)
        3'd0:    begin mul_a = {e1[1][31], e1[1]}; mul_b = {e2[2][31], e2[2]}; end
        3'd1:    begin mul_a = {e1[2][31], e1[2]}; mul_b = {e2[1][31], e2[1]}; end
        3'd2:    begin mul_a = {e1[2][31], e1[2]}; mul_b = {e2[0][31], e2[0]}; end
        3'd3:    begin mul_a = {e1[0][31], e1[0]}; mul_b = {e2[2][31], e2[2]}; end
        3'd4:    begin mul_a = {e1[0][31], e1[0]}; mul_b = {e2[1][31], e2[1]}; end
        3'd5:    begin mul_a = {e1[1][31], e1[1]}; mul_b = {e2[0][31], e2[0]}; end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) state <= F_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    case (state)
      F_IDLE: begin
        if (start) w <= vin;
      end
      F_EDGE: begin
        for (int k = 0; k < 3; k++) begin
          e1[k]       <= sat_diff(w[1][k], w[0][k]);
          e2[k]       <= sat_diff(w[2][k], w[0][k]);
          ctx.u[0][k] <= sat_diff(w[1][k], w[2][k]);
          ctx.u[1][k] <= sat_diff(w[2][k], w[0][k]);
          ctx.u[2][k] <= sat_diff(w[0][k], w[1][k]);
        end
        step <= '0;
      end
      F_CROSS: begin
        if (step[0]) cv[step[2:1]] <= cv[step[2:1]] - prod[63:0];
        else cv[step[2:1]] <= prod[63:0];
        step <= step + 1'b1;
      end
      F_MAX: begin
        msh       <= mmax;
        bl        <= '0;
        ctx.degen <= (mmax == '0);
        ctx.nrm   <= '0;
        ctx.lq    <= '0;
        ctx.s     <= '0;
        ctx.area  <= '0;
      end
      F_BLEN: begin
        if (|msh[63:4]) begin
          msh <= msh >> 4;
          bl  <= bl + 7'd4;
        end else if (msh != '0) begin
          msh <= msh >> 1;
          bl  <= bl + 7'd1;
        end
      end
      F_NORM: begin
        for (int k = 0; k < 3; k++) begin
          cmag[k] <= (s_c >= 0) ? CMAG_W'(cvmag[k] >> s_c[6:0])
                                : CMAG_W'(cvmag[k] << nsh[6:0]);
          csgn[k] <= cv[k][63];
        end
        ctx.s <= s_c;
        step  <= '0;
        sqx   <= '0;
      end
      F_SQ: begin
        sqx  <= sqx + SQ_W'(prod[CMAG_W*2-1:0]);
        step <= step + 1'b1;
        if (step == 3'd2) begin
          sqbit <= SQ_W'(1) << (SQ_W - 2);
          sqres <= '0;
        end
      end
      F_SQRT: begin
        if (sqbit != '0) begin
          if (sqx >= sqtry) begin
            sqx   <= sqx - sqtry;
            sqres <= (sqres >> 1) + sqbit;
          end else begin
            sqres <= sqres >> 1;
          end
          sqbit <= sqbit >> 2;
        end
      end
      F_AREA: begin
        ctx.lq   <= sqres[LQ_W-1:0];
        ctx.area <= area_c[30:0];
        nk       <= '0;
      end
      F_NWAIT: begin
        if (div_done) begin
          ctx.nrm[nk] <= div_q;
          nk          <= nk + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  tng_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (scale_mag(64'(cmag[nk]), FB8)),
    .den   (ctx.lq),
    .neg   (csgn[nk]),
    .done  (div_done),
    .q     (div_q)
  );

  // normalized length always has its top bit at 2^27 or above
  a_lq_range: assert property (@(posedge clk) disable iff (rst)
    state == F_AREA |-> sqres >= (SQ_W'(1) << (CMAG_W - 1)))
    else $error("square root result below normalized range");

  a_push_ctx: assert property (@(posedge clk) disable iff (rst)
    push && ctx.degen |-> ctx.lq == '0 && ctx.area == '0)
    else $error("degenerate context carries nonzero length");

endmodule

// ===== src/tng_back.sv =====
// Back end: per coordinate derivative, normal gradient division and result output.
`timescale 1ns / 1ps
module tng_back
  import tng_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        empty,
  output logic        pop,
  input  tri_ctx_t    ctx_in,
  output logic        valid,
  output logic [3:0]  coord_index,
  output logic [31:0] grad_nx,
  output logic [31:0] grad_ny,
  output logic [31:0] grad_nz,
  output logic [31:0] grad_area,
  output logic [31:0] normal_x,
  output logic [31:0] normal_y,
  output logic [31:0] normal_z,
  output logic [30:0] double_area,
  output logic        degenerate,
  output logic        last
);

  localparam logic signed [7:0] FB8   = 8'(FRAC_BITS);
  localparam logic signed [7:0] GA_SH = 8'(-(FRAC_BITS + 1));
  localparam logic [3:0]        LAST_IDX = 4'd8;

  back_state_t state, state_next;

  tri_ctx_t            c;
  logic [3:0]          idx;
  logic [1:0]          vtx, axis, bstep;
  logic signed [63:0]  p;
  logic signed [63:0]  t [3];
  logic [2:0]          got, dv_done, all_got;
  logic [31:0]         dq [3];

  logic [2:0][31:0]    uu;
  logic [1:0]          a1, a2;
  logic signed [32:0]  dc [3];
  logic [63:0]         pmag, pfmag;
  logic signed [34:0]  pf;
  logic signed [31:0]  mul_a;
  logic signed [34:0]  mul_b;
  logic signed [66:0]  prod;
  logic signed [7:0]   shn;
  logic                div_start, emit;

  // dc = e_axis x u_vertex
  always_comb begin
    uu = c.u[vtx];
    a1 = (axis == 2'd2) ? 2'd0 : axis + 1'b1;
    a2 = (axis == 2'd0) ? 2'd2 : axis - 1'b1;
    for (int k = 0; k < 3; k++) dc[k] = '0;
    dc[a1] = -$signed({uu[a2][31], uu[a2]});
    dc[a2] = $signed({uu[a1][31], uu[a1]});
  end

  assign pmag    = mag64(p);
  assign pfmag   = pmag >> FRAC_BITS;
  assign pf      = p[63] ? -$signed(35'(pfmag)) : $signed(35'(pfmag));
  assign prod    = mul_a * mul_b;
  assign shn     = FB8 - c.s;
  assign all_got = got | dv_done;

  always_comb begin
    state_next = state;
    case (state)
      B_IDLE:  if (!empty) state_next = ctx_in.degen ? B_ZERO : B_PROD;
      B_PROD:  if (bstep == 2'd2) state_next = B_TERM;
      B_TERM:  if (bstep == 2'd2) state_next = B_DIV;
      B_DIV:   state_next = B_WAIT;
      B_WAIT:  if (&all_got) state_next = (idx == LAST_IDX) ? B_IDLE : B_PROD;
      B_ZERO:  if (idx == LAST_IDX) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    pop       = (state == B_IDLE) && !empty;
    div_start = (state == B_DIV);
    emit      = ((state == B_WAIT) && (&all_got)) || (state == B_ZERO);
    mul_a     = $signed(c.nrm[bstep]);
    mul_b     = (state == B_TERM) ? pf : 35'(dc[bstep]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      valid <= 1'b0;
    end else begin
      state <= state_next;
      valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        if (!empty) c <= ctx_in;
        idx   <= '0;
        vtx   <= '0;
        axis  <= '0;
        bstep <= '0;
        p     <= '0;
      end
      B_PROD: begin
        p     <= p + prod[63:0];
        bstep <= (bstep == 2'd2) ? 2'd0 : bstep + 1'b1;
      end
      B_TERM: begin
        t[bstep] <= (64'(dc[bstep]) <<< FRAC_BITS) - prod[63:0];
        bstep    <= (bstep == 2'd2) ? 2'd0 : bstep + 1'b1;
      end
      B_DIV: begin
        got <= '0;
      end
      B_WAIT: begin
        got <= all_got;
      end
      default: begin
      end
    endcase

    if (emit) begin
      coord_index <= idx;
      last        <= (idx == LAST_IDX);
      degenerate  <= c.degen;
      if (state == B_ZERO) begin
        grad_nx     <= '0;
        grad_ny     <= '0;
        grad_nz     <= '0;
        grad_area   <= '0;
        normal_x    <= '0;
        normal_y    <= '0;
        normal_z    <= '0;
        double_area <= '0;
      end else begin
        grad_nx     <= dq[0];
        grad_ny     <= dq[1];
        grad_nz     <= dq[2];
        grad_area   <= sat_shift(pmag, GA_SH, p[63]);
        normal_x    <= c.nrm[0];
        normal_y    <= c.nrm[1];
        normal_z    <= c.nrm[2];
        double_area <= c.area;
      end
      idx   <= idx + 1'b1;
      p     <= '0;
      bstep <= '0;
      if (axis == 2'd2) begin
        axis <= '0;
        vtx  <= vtx + 1'b1;
      end else begin
        axis <= axis + 1'b1;
      end
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_div
    tng_div u_div (
      .clk   (clk),
      .rst   (rst),
      .start (div_start),
      .num   (scale_mag(mag64(t[k]), shn)),
      .den   (c.lq),
      .neg   (t[k][63]),
      .done  (dv_done[k]),
      .q     (dq[k])
    );
  end

  a_last_idx: assert property (@(posedge clk) disable iff (rst)
    valid && last |-> coord_index == LAST_IDX)
    else $error("last marked on wrong coordinate");

  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    valid && degenerate |-> grad_nx == '0 && grad_area == '0 && normal_z == '0
                            && double_area == '0)
    else $error("degenerate result carries nonzero data");

  a_after_last: assert property (@(posedge clk) disable iff (rst)
    valid && last |=> !valid)
    else $error("result right after last of a triangle");

  a_seq_idx: assert property (@(posedge clk) disable iff (rst)
    valid && !last |=> !valid || coord_index == $past(coord_index) + 4'd1)
    else $error("coordinate index out of order");

endmodule

// ===== src/triangle_normal_gradient.sv =====
// Top level of the triangle normal and area gradient block.
// The front end forms the cross product on one shared multiplier, then runs a
//   bit-length scan, a 30-step square root and three normal divides; the back end
//   then makes one pass per coordinate, with a 31-step divider loop per coordinate
//   for nine coordinates, and takes the next triangle only after the last coordinate.
//   Degenerate triangles skip the square root, the divides and the divider loops.
// Reset clears control state and the queue; the receiver cannot stall results.
`timescale 1ns / 1ps
module triangle_normal_gradient
  import tng_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] v1_x,
  input  logic signed [31:0] v1_y,
  input  logic signed [31:0] v1_z,
  input  logic signed [31:0] v2_x,
  input  logic signed [31:0] v2_y,
  input  logic signed [31:0] v2_z,
  input  logic signed [31:0] v3_x,
  input  logic signed [31:0] v3_y,
  input  logic signed [31:0] v3_z,
  output logic               valid,
  output logic [3:0]         coord_index,
  output logic signed [31:0] grad_nx,
  output logic signed [31:0] grad_ny,
  output logic signed [31:0] grad_nz,
  output logic signed [31:0] grad_area,
  output logic signed [31:0] normal_x,
  output logic signed [31:0] normal_y,
  output logic signed [31:0] normal_z,
  output logic [30:0]        double_area,
  output logic               degenerate,
  output logic               last
);

  // vertex coordinates as vin[vertex][axis]
  logic [2:0][2:0][31:0] vin;
  tri_ctx_t              q_in, q_out;
  logic                  q_push, q_pop, q_full, q_empty;

  assign vin[0] = {v1_z, v1_y, v1_x};
  assign vin[1] = {v2_z, v2_y, v2_x};
  assign vin[2] = {v3_z, v3_y, v3_x};

  // front: takes a new triangle once it has pushed the last one into the queue,
  // and waits to push while the queue is full, so it can be held by the back end
  tng_front #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .vin   (vin),
    .busy  (busy),
    .full  (q_full),
    .push  (q_push),
    .ctx   (q_in)
  );

  // two triangle contexts of slack between the halves
  tng_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .pop   (q_pop),
    .din   (q_in),
    .dout  (q_out),
    .full  (q_full),
    .empty (q_empty)
  );

  // back: nine results per triangle, one strobe cycle each
  tng_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .empty       (q_empty),
    .pop         (q_pop),
    .ctx_in      (q_out),
    .valid       (valid),
    .coord_index (coord_index),
    .grad_nx     (grad_nx),
    .grad_ny     (grad_ny),
    .grad_nz     (grad_nz),
    .grad_area   (grad_area),
    .normal_x    (normal_x),
    .normal_y    (normal_y),
    .normal_z    (normal_z),
    .double_area (double_area),
    .degenerate  (degenerate),
    .last        (last)
  );

endmodule
